FILE: rtl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg: shared types and constants of the bitmap upscale printer
// Line geometry, row store sizing, register indexes and the row command
// that travels from the byte front end to the line builder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

  localparam int LINE_DOTS  = 384;
  localparam int MAX_SCALE  = 8;
  localparam int ROW_BYTES  = 48;
  localparam int LINE_WORDS = (LINE_DOTS + 63) / 64;
  localparam int LINE_BITS  = LINE_WORDS * 64;
  localparam int LINE_PAD   = LINE_BITS - LINE_DOTS;

  localparam int BYTE_W   = $clog2(ROW_BYTES + 1);
  localparam int PX_W     = $clog2(ROW_BYTES * 8 + 1);
  localparam int DOT_W    = $clog2(LINE_DOTS + 1);
  localparam int SCALE_W  = 4;
  localparam int OFF_W    = 13;
  localparam int RUN_W    = OFF_W - 1;
  localparam int MEM_AW   = $clog2(2 * ROW_BYTES);
  localparam int WORD_IW  = 3;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  localparam logic [CFG_IW-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SCALE_FACTOR  = 2'd2;

  localparam logic [7:0] PIXEL_MSB = 8'h80;

  typedef struct packed {
    logic                    bank;
    logic [BYTE_W-1:0]       nbytes;
    logic [SCALE_W-1:0]      scale;
    logic signed [OFF_W-1:0] offset;
    logic                    image_end;
  } row_cmd_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic bank,
                                                 input logic [BYTE_W-1:0] idx);
    logic [MEM_AW-1:0] base;
    base = bank ? MEM_AW'(ROW_BYTES) : '0;
    return base + MEM_AW'(idx);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bitmap_upscale_center_printer.sv
// ----------------------------------------------------------------------------
// bitmap_upscale_center_printer: 1bpp row upscaler for a dot-line printer
// Source bytes enter on the slave stream, MSB leftmost, row after row. Each
// complete row goes out scale times as centered printer lines of six words.
//
// Registers are written on the cfg channel (index 0 width, 1 height,
// 2 scale); the user must write them only while the block is idle, which
// the block itself does not enforce; cfg_ready_o is always high. Bytes are
// accepted one per cycle while s_axis_tready_o is high. Two row banks let
// one row be received while the previous one is printed; s_axis_tready_o
// drops only when both banks hold rows not yet printed in full. Once a row
// is queued, the line builder leaves its idle state, then shifts the line
// in one dot per cycle, apart from a fetch step per source byte read and a
// skip step per clipped pixel when the picture is wider than the line. The
// words then follow at one per cycle, scale * 6 per row. A stall on
// m_axis_tready_i holds the output register and then the builder.
// Reset empties the row queue, clears the row and byte positions and loads
// width 384, height 1 and scale 1; the row store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_upscale_center_printer (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [bmp_pkg::CFG_IW-1:0]   cfg_index_i,
  input  wire [bmp_pkg::CFG_DW-1:0]   cfg_data_i,
  input  wire                         s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire [7:0]                   s_axis_tdata_i,   // [7:0] pixel_byte
  output logic                        m_axis_tvalid_o,
  input  wire                         m_axis_tready_i,
  output logic [71:0]                 m_axis_tdata_o,   // [63:0] line_word, [66:64] word_index
  output logic                        m_axis_tlast_o,   // last_of_line
  output logic                        m_axis_tuser_o    // [0] last_of_image
);

  logic                          queue_full;
  logic                          push;
  bmp_pkg::row_cmd_t             push_cmd;
  bmp_pkg::mem_wr_t              mem_wr;
  logic                          pop;
  logic                          head_valid;
  bmp_pkg::row_cmd_t             head_cmd;
  logic [63:0]                   out_word;
  logic [bmp_pkg::WORD_IW-1:0]   out_index;

  assign cfg_ready_o = 1'b1;

  bmp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_data_i  (s_axis_tdata_i),
    .byte_ready_o (s_axis_tready_o),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .mem_wr_o     (mem_wr)
  );

  bmp_cmd_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  bmp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mem_wr_i         (mem_wr),
    .head_valid_i     (head_valid),
    .head_cmd_i       (head_cmd),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_word_o       (out_word),
    .out_index_o      (out_index),
    .out_last_line_o  (m_axis_tlast_o),
    .out_last_image_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {5'b00000, out_index, out_word};

endmodule

`default_nettype wire

FILE: rtl/bmp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bmp_cmd_fifo: two-entry row command queue
// Entry i owns row store bank i; an entry leaves only when its row has
// been printed in full, so a full queue means both banks are in use.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_cmd_fifo (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  bmp_pkg::row_cmd_t push_cmd_i,
  output logic              full_o,
  input  wire               pop_i,
  output logic              head_valid_o,
  output bmp_pkg::row_cmd_t head_cmd_o
);

  bmp_pkg::row_cmd_t entry_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign full_o       = count_q[1];
  assign head_valid_o = (count_q != 2'd0);
  assign head_cmd_o   = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: rtl/bmp_front.sv
// ----------------------------------------------------------------------------
// bmp_front: byte intake and row classification
// Holds the configuration registers, stores incoming bytes into the free
// row bank and issues a row command with the line geometry at row end.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  input  wire [bmp_pkg::CFG_IW-1:0]    cfg_index_i,
  input  wire [bmp_pkg::CFG_DW-1:0]    cfg_data_i,
  input  wire                          byte_valid_i,
  input  wire [7:0]                    byte_data_i,
  output logic                         byte_ready_o,
  input  wire                          queue_full_i,
  output logic                         push_o,
  output bmp_pkg::row_cmd_t            push_cmd_o,
  output bmp_pkg::mem_wr_t             mem_wr_o
);

  logic [8:0]                   width_q;
  logic [15:0]                  height_q;
  logic [bmp_pkg::SCALE_W-1:0]  scale_q;
  logic [bmp_pkg::BYTE_W-1:0]   byte_pos_q, byte_pos_d;
  logic [15:0]                  row_pos_q, row_pos_d;
  logic                         bank_q, bank_d;

  logic                         accept;
  logic                         row_done;
  logic [5:0]                   raw_bytes;
  logic [bmp_pkg::BYTE_W-1:0]   nbytes;
  logic [bmp_pkg::SCALE_W-1:0]  scale;
  logic [15:0]                  height;
  logic                         image_end;
  logic [9:0]                   pix_prod;
  logic signed [bmp_pkg::OFF_W:0] diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'(bmp_pkg::ROW_BYTES * 8);
      height_q <= 16'd1;
      scale_q  <= bmp_pkg::SCALE_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bmp_pkg::REG_SOURCE_WIDTH:  width_q  <= cfg_data_i[8:0];
        bmp_pkg::REG_SOURCE_HEIGHT: height_q <= cfg_data_i[15:0];
        bmp_pkg::REG_SCALE_FACTOR:  scale_q  <= cfg_data_i[bmp_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    raw_bytes = width_q[8:3];
    if (raw_bytes == 6'd0) begin
      nbytes = bmp_pkg::BYTE_W'(1);
    end else if (raw_bytes > 6'(bmp_pkg::ROW_BYTES)) begin
      nbytes = bmp_pkg::BYTE_W'(bmp_pkg::ROW_BYTES);
    end else begin
      nbytes = bmp_pkg::BYTE_W'(raw_bytes);
    end

    if (scale_q == '0) begin
      scale = bmp_pkg::SCALE_W'(1);
    end else if (scale_q > bmp_pkg::SCALE_W'(bmp_pkg::MAX_SCALE)) begin
      scale = bmp_pkg::SCALE_W'(bmp_pkg::MAX_SCALE);
    end else begin
      scale = scale_q;
    end

    height    = (height_q == 16'd0) ? 16'd1 : height_q;
    image_end = ({1'b0, row_pos_q} + 17'd1) >= {1'b0, height};

    pix_prod = 10'(nbytes) * 10'(scale);
    diff     = $signed((bmp_pkg::OFF_W + 1)'(bmp_pkg::LINE_DOTS))
             - $signed({1'b0, (bmp_pkg::OFF_W)'({pix_prod, 3'b000})});
  end

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign row_done     = ((bmp_pkg::BYTE_W + 1)'(byte_pos_q) + 1'b1)
                        >= (bmp_pkg::BYTE_W + 1)'(nbytes);

  always_comb begin
    byte_pos_d = byte_pos_q;
    row_pos_d  = row_pos_q;
    bank_d     = bank_q;
    if (accept) begin
      if (row_done) begin
        byte_pos_d = '0;
        row_pos_d  = image_end ? 16'd0 : row_pos_q + 16'd1;
        bank_d     = !bank_q;
      end else begin
        byte_pos_d = byte_pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= '0;
      row_pos_q  <= '0;
      bank_q     <= 1'b0;
    end else begin
      byte_pos_q <= byte_pos_d;
      row_pos_q  <= row_pos_d;
      bank_q     <= bank_d;
    end
  end

  assign push_o               = accept && row_done;
  assign push_cmd_o.bank      = bank_q;
  assign push_cmd_o.nbytes    = nbytes;
  assign push_cmd_o.scale     = scale;
  assign push_cmd_o.offset    = bmp_pkg::OFF_W'(diff >>> 1);
  assign push_cmd_o.image_end = image_end;

  assign mem_wr_o.en   = accept;
  assign mem_wr_o.addr = bmp_pkg::mem_addr(bank_q, byte_pos_q);
  assign mem_wr_o.data = byte_data_i;

endmodule

`default_nettype wire

FILE: rtl/bmp_back.sv
// ----------------------------------------------------------------------------
// bmp_back: line builder and word emitter
// Owns the two-bank row store, shifts the scaled and centered row into a
// line register one dot per cycle between fetches, then sends it scale times.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_back (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  bmp_pkg::mem_wr_t              mem_wr_i,
  input  wire                           head_valid_i,
  input  bmp_pkg::row_cmd_t             head_cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [63:0]                   out_word_o,
  output logic [bmp_pkg::WORD_IW-1:0]   out_index_o,
  output logic                          out_last_line_o,
  output logic                          out_last_image_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SKIP  = 7'b0000010,
    ST_LEAD  = 7'b0000100,
    ST_FETCH = 7'b0001000,
    ST_PIX   = 7'b0010000,
    ST_TAIL  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } back_state_e;

  logic [7:0] mem_q [2 * bmp_pkg::ROW_BYTES];
  logic [7:0] rd_q;

  back_state_e                   state_q, state_d;
  logic [bmp_pkg::LINE_DOTS-1:0] line_q, line_d;
  logic [bmp_pkg::DOT_W-1:0]     dot_q, dot_d;
  logic [bmp_pkg::RUN_W-1:0]     run_q, run_d;
  logic [bmp_pkg::PX_W-1:0]      px_q, px_d;
  logic [2:0]                    sub_q, sub_d;
  logic [bmp_pkg::SCALE_W-1:0]   rep_q, rep_d;
  logic [bmp_pkg::WORD_IW-1:0]   word_q, word_d;

  logic                          ov_q, ov_d;
  logic [63:0]                   ow_q;
  logic [bmp_pkg::WORD_IW-1:0]   oi_q;
  logic                          oll_q, oli_q;

  logic [bmp_pkg::PX_W-1:0]      pw;
  logic [bmp_pkg::SCALE_W-1:0]   s_last;
  logic                          dot_full;
  logic                          pix_bit;
  logic                          load;
  logic                          word_last, rep_last;
  logic [bmp_pkg::LINE_BITS-1:0] padded;
  logic [63:0]                   words [bmp_pkg::LINE_WORDS];
  logic [bmp_pkg::RUN_W-1:0]     neg_off;

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem_q[mem_wr_i.addr] <= mem_wr_i.data;
    end
    rd_q <= mem_q[bmp_pkg::mem_addr(head_cmd_i.bank, px_q[bmp_pkg::PX_W-1:3])];
  end

  assign pw       = bmp_pkg::PX_W'({head_cmd_i.nbytes, 3'b000});
  assign s_last   = head_cmd_i.scale - 1'b1;
  assign dot_full = ((bmp_pkg::DOT_W + 1)'(dot_q) + 1'b1)
                    == (bmp_pkg::DOT_W + 1)'(bmp_pkg::LINE_DOTS);
  assign pix_bit  = |(rd_q & (bmp_pkg::PIXEL_MSB >> px_q[2:0]));
  assign neg_off  = bmp_pkg::RUN_W'(-head_cmd_i.offset);

  assign padded = bmp_pkg::LINE_BITS'(line_q) << bmp_pkg::LINE_PAD;

  always_comb begin
    for (int i = 0; i < bmp_pkg::LINE_WORDS; i++) begin
      words[i] = padded[bmp_pkg::LINE_BITS-1-64*i -: 64];
    end
  end

  assign word_last = (word_q == bmp_pkg::WORD_IW'(bmp_pkg::LINE_WORDS - 1));
  assign rep_last  = (rep_q == s_last);
  assign load      = (state_q == ST_EMIT) && (!ov_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    line_d  = line_q;
    dot_d   = dot_q;
    run_d   = run_q;
    px_d    = px_q;
    sub_d   = sub_q;
    rep_d   = rep_q;
    word_d  = word_q;
    pop_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        px_d   = '0;
        sub_d  = '0;
        dot_d  = '0;
        rep_d  = '0;
        word_d = '0;
        if (head_valid_i) begin
          if (head_cmd_i.offset < 0) begin
            run_d   = neg_off;
            state_d = ST_SKIP;
          end else if (head_cmd_i.offset > 0) begin
            run_d   = bmp_pkg::RUN_W'(head_cmd_i.offset);
            state_d = ST_LEAD;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_SKIP: begin
        if (run_q >= bmp_pkg::RUN_W'(head_cmd_i.scale)) begin
          run_d = run_q - bmp_pkg::RUN_W'(head_cmd_i.scale);
          px_d  = px_q + 1'b1;
        end else begin
          sub_d   = run_q[2:0];
          state_d = ST_FETCH;
        end
      end
      ST_LEAD: begin
        line_d = {line_q[bmp_pkg::LINE_DOTS-2:0], 1'b0};
        dot_d  = dot_q + 1'b1;
        run_d  = run_q - 1'b1;
        if (run_q == bmp_pkg::RUN_W'(1)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_PIX;
      end
      ST_PIX: begin
        line_d = {line_q[bmp_pkg::LINE_DOTS-2:0], pix_bit};
        dot_d  = dot_q + 1'b1;
        if (dot_full) begin
          state_d = ST_EMIT;
        end else if ({1'b0, sub_q} == s_last) begin
          sub_d = '0;
          px_d  = px_q + 1'b1;
          if ((px_q + 1'b1) == pw) begin
            state_d = ST_TAIL;
          end else if (px_q[2:0] == 3'd7) begin
            state_d = ST_FETCH;
          end
        end else begin
          sub_d = sub_q + 1'b1;
        end
      end
      ST_TAIL: begin
        line_d = {line_q[bmp_pkg::LINE_DOTS-2:0], 1'b0};
        dot_d  = dot_q + 1'b1;
        if (dot_full) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (word_last) begin
            word_d = '0;
            rep_d  = rep_q + 1'b1;
            if (rep_last) begin
              pop_o   = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            word_d = word_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      dot_q   <= '0;
      run_q   <= '0;
      px_q    <= '0;
      sub_q   <= '0;
      rep_q   <= '0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      dot_q   <= dot_d;
      run_q   <= run_d;
      px_q    <= px_d;
      sub_q   <= sub_d;
      rep_q   <= rep_d;
      word_q  <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    if (load) begin
      ow_q  <= words[word_q];
      oi_q  <= word_q;
      oll_q <= word_last;
      oli_q <= word_last && rep_last && head_cmd_i.image_end;
    end
  end

  assign out_valid_o      = ov_q;
  assign out_word_o       = ow_q;
  assign out_index_o      = oi_q;
  assign out_last_line_o  = oll_q;
  assign out_last_image_o = oli_q;

endmodule

`default_nettype wire
